// ===== sv/rfds_pkg.sv =====
// Shared types and codes for the ready queue and delta sleep list scheduler.
`default_nettype none
package rfds_pkg;
    localparam logic [1:0] MODE_ENQ   = 2'd0;
    localparam logic [1:0] MODE_DEQ   = 2'd1;
    localparam logic [1:0] MODE_SLEEP = 2'd2;
    localparam logic [1:0] MODE_TICK  = 2'd3;

    localparam int IN_BITS  = 40;
    localparam int OUT_BITS = 16;

    // Datapath operations driven by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_ENQ,
        OP_DEQ,
        OP_SLEEP_INIT,
        OP_SLEEP_STEP,
        OP_SLEEP_LINK,
        OP_TICK_DEC,
        OP_TICK_WAKE
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic enq_ok;
        logic deq_ok;
        logic sleep_ok;
        logic tick_ok;
        logic walk_more;
        logic wake_more;
    } status_t;
endpackage
`default_nettype wire

// ===== sv/rfds_datapath.sv =====
// Datapath: link tables, delay table, walk registers and result register.
`default_nettype none
module rfds_datapath #(
    parameter int NUM_THREADS = 16,
    parameter int TIME_BITS   = 32
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  rfds_pkg::cmd_t      cmd,
    output rfds_pkg::status_t   status,
    input  wire  [1:0]          in_mode,
    input  wire  [3:0]          in_thread,
    input  wire  [31:0]         in_duration,
    output logic [3:0]          res_thread,
    output logic                res_found,
    output logic [4:0]          res_woken
);
    localparam int PW = $clog2(NUM_THREADS + 1);
    localparam int IW = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
    localparam int SW = $clog2(NUM_THREADS + 1);
    localparam logic [PW-1:0] NIL = PW'(NUM_THREADS);

    logic [PW-1:0] rnext_reg [NUM_THREADS];
    logic [PW-1:0] snext_reg [NUM_THREADS];
    logic [TIME_BITS-1:0] delta_reg [NUM_THREADS];
    logic [NUM_THREADS-1:0] blocked_reg;
    logic [PW-1:0] rhead_reg, rtail_reg, shead_reg;

    logic [1:0]           mode_reg;
    logic [PW-1:0]        tid_reg;
    logic [TIME_BITS-1:0] dur_reg, total_reg;
    logic [PW-1:0]        prev_reg, cur_reg;
    logic [SW-1:0]        steps_reg;
    logic [SW-1:0]        woken_reg;

    logic cur_live, prev_live, rh_live, sh_live, rt_live, tid_live, link_cur;
    logic [TIME_BITS-1:0] rem, cur_delta, head_delta, dnew;

    assign cur_live  = cur_reg < NIL;
    assign prev_live = prev_reg < NIL;
    assign rh_live   = rhead_reg < NIL;
    assign rt_live   = rtail_reg < NIL;
    assign sh_live   = shead_reg < NIL;
    assign tid_live  = tid_reg < NIL;
    assign link_cur  = cur_live && (cur_reg != tid_reg);
    assign rem       = dur_reg - total_reg;
    assign cur_delta = cur_live ? delta_reg[cur_reg[IW-1:0]] : '0;
    assign head_delta = sh_live ? delta_reg[shead_reg[IW-1:0]] : '0;
    assign dnew      = rem;

    assign status.enq_ok    = tid_live;
    assign status.deq_ok    = rh_live;
    assign status.sleep_ok  = tid_live && (dur_reg != '0);
    assign status.tick_ok   = sh_live;
    assign status.walk_more = cur_live && (steps_reg < SW'(NUM_THREADS))
                              && (cur_delta <= rem);
    assign status.wake_more = sh_live && (woken_reg < SW'(NUM_THREADS))
                              && (head_delta == '0);

    assign res_thread = mode_reg == rfds_pkg::MODE_DEQ ? 4'(tid_reg) : 4'd0;
    assign res_found  = (mode_reg == rfds_pkg::MODE_DEQ) && tid_live;
    assign res_woken  = (mode_reg == rfds_pkg::MODE_TICK) ? 5'(woken_reg) : 5'd0;

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            rfds_pkg::OP_LOAD:
            begin
                mode_reg  <= in_mode;
                dur_reg   <= TIME_BITS'(in_duration);
                woken_reg <= '0;
                tid_reg   <= (in_mode == rfds_pkg::MODE_DEQ) ? NIL : PW'(in_thread);
            end
            rfds_pkg::OP_DEQ:
                tid_reg <= rhead_reg;
            rfds_pkg::OP_SLEEP_INIT:
            begin
                prev_reg  <= NIL;
                cur_reg   <= shead_reg;
                total_reg <= '0;
                steps_reg <= '0;
            end
            rfds_pkg::OP_SLEEP_STEP:
            begin
                total_reg <= total_reg + cur_delta;
                prev_reg  <= cur_reg;
                cur_reg   <= snext_reg[cur_reg[IW-1:0]];
                steps_reg <= steps_reg + 1'b1;
            end
            rfds_pkg::OP_TICK_WAKE:
                woken_reg <= woken_reg + 1'b1;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rhead_reg   <= NIL;
            rtail_reg   <= NIL;
            shead_reg   <= NIL;
            blocked_reg <= '0;
            for (int i = 0; i < NUM_THREADS; i++)
            begin
                rnext_reg[i] <= NIL;
                snext_reg[i] <= NIL;
            end
        end
        else
        begin
            case (cmd.op)
                rfds_pkg::OP_ENQ:
                begin
                    if (rt_live)
                        rnext_reg[rtail_reg[IW-1:0]] <= tid_reg;
                    // a thread appended behind itself keeps the self link
                    if (!(rt_live && rtail_reg == tid_reg))
                        rnext_reg[tid_reg[IW-1:0]] <= NIL;
                    rtail_reg <= tid_reg;
                    if (!rh_live)
                        rhead_reg <= tid_reg;
                end
                rfds_pkg::OP_DEQ:
                begin
                    rhead_reg <= rnext_reg[rhead_reg[IW-1:0]];
                    if (!(rnext_reg[rhead_reg[IW-1:0]] < NIL))
                        rtail_reg <= NIL;
                    rnext_reg[rhead_reg[IW-1:0]] <= NIL;
                end
                rfds_pkg::OP_SLEEP_INIT:
                    // detach the thread before the walk
                    snext_reg[tid_reg[IW-1:0]] <= NIL;
                rfds_pkg::OP_SLEEP_LINK:
                begin
                    blocked_reg[tid_reg[IW-1:0]] <= 1'b1;
                    if (!prev_live)
                        shead_reg <= tid_reg;
                    else if (!(link_cur && prev_reg == tid_reg))
                        snext_reg[prev_reg[IW-1:0]] <= tid_reg;
                    // the successor link wins when the thread is its own predecessor
                    if (link_cur)
                        snext_reg[tid_reg[IW-1:0]] <= cur_reg;
                end
                rfds_pkg::OP_TICK_WAKE:
                begin
                    shead_reg <= snext_reg[shead_reg[IW-1:0]];
                    snext_reg[shead_reg[IW-1:0]] <= NIL;
                    blocked_reg[shead_reg[IW-1:0]] <= 1'b0;
                    if (rt_live)
                        rnext_reg[rtail_reg[IW-1:0]] <= shead_reg;
                    if (!(rt_live && rtail_reg == shead_reg))
                        rnext_reg[shead_reg[IW-1:0]] <= NIL;
                    rtail_reg <= shead_reg;
                    if (!rh_live)
                        rhead_reg <= shead_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            rfds_pkg::OP_SLEEP_LINK:
            begin
                if (link_cur)
                    delta_reg[cur_reg[IW-1:0]] <= cur_delta - dnew;
                delta_reg[tid_reg[IW-1:0]] <= dnew;
            end
            rfds_pkg::OP_TICK_DEC:
                delta_reg[shead_reg[IW-1:0]] <= head_delta - 1'b1;
            default:
            begin
            end
        endcase
    end
endmodule
`default_nettype wire

// ===== sv/rfds_ctrl.sv =====
// Controller: sequences one request through the datapath operations.
`default_nettype none
module rfds_ctrl (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire                out_ready,
    input  wire  [1:0]         in_mode,
    output rfds_pkg::cmd_t     cmd,
    input  rfds_pkg::status_t  status
);
    typedef enum logic [2:0] {
        S_IDLE, S_DISPATCH, S_WALK, S_WAKE, S_DONE
    } state_t;

    state_t state_reg;
    logic [1:0] mode_reg;

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = state_reg == S_DONE;

    always_comb
    begin
        cmd.op = rfds_pkg::OP_NONE;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                    cmd.op = rfds_pkg::OP_LOAD;
            S_DISPATCH:
                case (mode_reg)
                    rfds_pkg::MODE_ENQ:
                        if (status.enq_ok)
                            cmd.op = rfds_pkg::OP_ENQ;
                    rfds_pkg::MODE_DEQ:
                        if (status.deq_ok)
                            cmd.op = rfds_pkg::OP_DEQ;
                    rfds_pkg::MODE_SLEEP:
                        if (status.sleep_ok)
                            cmd.op = rfds_pkg::OP_SLEEP_INIT;
                    default:
                        if (status.tick_ok)
                            cmd.op = rfds_pkg::OP_TICK_DEC;
                endcase
            S_WALK:
                cmd.op = status.walk_more ? rfds_pkg::OP_SLEEP_STEP
                                          : rfds_pkg::OP_SLEEP_LINK;
            S_WAKE:
                if (status.wake_more)
                    cmd.op = rfds_pkg::OP_TICK_WAKE;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg  <= rfds_pkg::MODE_ENQ;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                    if (in_valid)
                    begin
                        mode_reg  <= in_mode;
                        state_reg <= S_DISPATCH;
                    end
                S_DISPATCH:
                    if (cmd.op == rfds_pkg::OP_SLEEP_INIT)
                        state_reg <= S_WALK;
                    else if (cmd.op == rfds_pkg::OP_TICK_DEC)
                        state_reg <= S_WAKE;
                    else
                        state_reg <= S_DONE;
                S_WALK:
                    if (!status.walk_more)
                        state_reg <= S_DONE;
                S_WAKE:
                    if (!status.wake_more)
                        state_reg <= S_DONE;
                S_DONE:
                    if (out_ready)
                        state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("ready and valid together");
    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK && !status.walk_more |=> out_valid)
        else $error("walk did not finish");
endmodule
`default_nettype wire

// ===== sv/ready_fifo_and_delta_sleep_list.sv =====
// Top level of the ready queue and delta sleep list scheduler.
// One request at a time: each request is loaded on accept, then dispatched;
// a sleep then walks the sleep list (up to NUM_THREADS entries) before
// linking the thread in, and a tick wakes threads from the list head (up to
// NUM_THREADS); the walk through the link tables goes one entry per cycle.
// A sleep with zero duration or an empty-list tick skips the walk. The next
// request is accepted in the cycle after the result is taken.
`default_nettype none
module ready_fifo_and_delta_sleep_list #(
    parameter int NUM_THREADS = 16,
    parameter int TIME_BITS   = 32
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [39:0] s_tdata,  // mode[1:0], thread_id[5:2], duration[37:6]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata   // out_thread[3:0], found[4], woken_count[9:5]
);
    rfds_pkg::cmd_t    cmd;
    rfds_pkg::status_t status;
    logic [3:0] res_thread;
    logic       res_found;
    logic [4:0] res_woken;

    rfds_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .in_mode(s_tdata[1:0]), .cmd(cmd), .status(status)
    );

    rfds_datapath #(.NUM_THREADS(NUM_THREADS), .TIME_BITS(TIME_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
        .in_mode(s_tdata[1:0]), .in_thread(s_tdata[5:2]),
        .in_duration(s_tdata[37:6]),
        .res_thread(res_thread), .res_found(res_found), .res_woken(res_woken)
    );

    assign m_tdata = {6'd0, res_woken, res_found, res_thread};
endmodule
`default_nettype wire

// ===== verif/tb_ready_fifo_and_delta_sleep_list.sv =====
// Self-checking bench for the ready queue and delta sleep list scheduler.
`default_nettype none
module tb_ready_fifo_and_delta_sleep_list;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NT = 16;
    localparam logic [4:0] NIL = 5'd16;

    typedef struct packed {
        logic [4:0] woken;
        logic       found;
        logic [3:0] thread;
    } sched_result_t;

    typedef struct {
        logic [1:0]  mode;
        logic [3:0]  tid;
        logic [31:0] dur;
        logic        has_exp;
        logic [3:0]  exp_thread;
        logic        exp_found;
        logic [4:0]  exp_woken;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    ready_fifo_and_delta_sleep_list dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // predictor state
    logic [4:0]  rdy_link [NT];
    logic [4:0]  rdy_head;
    logic [4:0]  rdy_tail;
    logic [4:0]  slp_link [NT];
    logic [31:0] slp_delta [NT];
    logic [4:0]  slp_head;
    logic        blocked [NT];

    sched_result_t expected_q[$];
    int errors;
    int result_count;
    int accepted;
    int sleeps_seen;
    int woken_total;
    logic drain_mode;

    initial
    begin
        clk = 1'b0;
    end
    always #4 clk = ~clk;

    task automatic sched_reset();
        for (int i = 0; i < NT; i++)
        begin
            rdy_link[i] = NIL;
            slp_link[i] = NIL;
            slp_delta[i] = '0;
            blocked[i] = 1'b0;
        end
        rdy_head = NIL;
        rdy_tail = NIL;
        slp_head = NIL;
    endtask

    function automatic void ready_append(input logic [4:0] t);
        rdy_link[t[3:0]] = NIL;
        if (rdy_tail != NIL)
            rdy_link[rdy_tail[3:0]] = t;
        rdy_tail = t;
        if (rdy_head == NIL)
            rdy_head = t;
    endfunction

    function automatic sched_result_t schedule_step(input logic [1:0] mode,
                                                    input logic [3:0] tid,
                                                    input logic [31:0] dur);
        sched_result_t r;
        logic [4:0]  prv;
        logic [4:0]  cur;
        logic [4:0]  h;
        logic [31:0] total;
        logic [31:0] d;
        int steps;
        r = '0;
        case (mode)
            rfds_pkg::MODE_ENQ:
                ready_append({1'b0, tid});
            rfds_pkg::MODE_DEQ:
                if (rdy_head != NIL)
                begin
                    h = rdy_head;
                    rdy_head = rdy_link[h[3:0]];
                    if (rdy_head == NIL)
                        rdy_tail = NIL;
                    rdy_link[h[3:0]] = NIL;
                    r.thread = h[3:0];
                    r.found = 1'b1;
                end
            rfds_pkg::MODE_SLEEP:
                if (dur != 0)
                begin
                    prv = NIL;
                    cur = slp_head;
                    total = '0;
                    steps = 0;
                    slp_link[tid] = NIL;
                    blocked[tid] = 1'b1;
                    while (cur != NIL && steps < NT && slp_delta[cur[3:0]] <= dur - total)
                    begin
                        total = total + slp_delta[cur[3:0]];
                        prv = cur;
                        cur = slp_link[cur[3:0]];
                        steps++;
                    end
                    d = dur - total;
                    slp_delta[tid] = d;
                    if (prv != NIL)
                        slp_link[prv[3:0]] = {1'b0, tid};
                    else
                        slp_head = {1'b0, tid};
                    if (cur != NIL && cur[3:0] != tid)
                    begin
                        slp_link[tid] = cur;
                        slp_delta[cur[3:0]] = slp_delta[cur[3:0]] - d;
                    end
                end
            default:
                if (slp_head != NIL)
                begin
                    slp_delta[slp_head[3:0]] = slp_delta[slp_head[3:0]] - 32'd1;
                    while (slp_head != NIL && r.woken < NT && slp_delta[slp_head[3:0]] == 0)
                    begin
                        h = slp_head;
                        slp_head = slp_link[h[3:0]];
                        slp_link[h[3:0]] = NIL;
                        blocked[h[3:0]] = 1'b0;
                        ready_append(h);
                        r.woken = r.woken + 5'd1;
                    end
                end
        endcase
        return r;
    endfunction

    // Drive one request; predicted result is queued on acceptance.
    task automatic send_request(input stim_row_t row);
        sched_result_t r;
        if (!drain_mode && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, row.dur, row.tid, row.mode};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        r = schedule_step(row.mode, row.tid, row.dur);
        if (row.has_exp && (r.thread != row.exp_thread || r.found != row.exp_found
                            || r.woken != row.exp_woken))
        begin
            errors++;
            if (errors <= 10)
                $display("table row disagrees with predictor: mode %0d exp %0d/%0d/%0d",
                         row.mode, row.exp_thread, row.exp_found, row.exp_woken);
        end
        expected_q.push_back(r);
        accepted++;
        if (row.mode == rfds_pkg::MODE_SLEEP)
            sleeps_seen++;
    endtask

    // sink side with random backpressure
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!drain_mode && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        sched_result_t got;
        sched_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[9:0];
            result_count++;
            woken_total += got.woken;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %h", m_tdata);
            end
            else
            begin
                want = expected_q.pop_front();
                if (got != want || m_tdata[15:10] != 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: exp thr %0d fnd %0d woke %0d, ",
                                  "got thr %0d fnd %0d woke %0d"},
                                 want.thread, want.found, want.woken,
                                 got.thread, got.found, got.woken);
                end
            end
        end
    end

    function automatic stim_row_t mk(input logic [1:0] m, input logic [3:0] t,
                                     input logic [31:0] d, input logic he,
                                     input logic [3:0] et, input logic ef,
                                     input logic [4:0] ew);
        stim_row_t r;
        r.mode = m; r.tid = t; r.dur = d; r.has_exp = he;
        r.exp_thread = et; r.exp_found = ef; r.exp_woken = ew;
        return r;
    endfunction

    initial
    begin
        stim_row_t dir_tab[$];
        stim_row_t row;
        logic [31:0] d;
        int pick;
        int guard;
        s_tvalid = 1'b0;
        s_tdata = '0;
        rst_n = 1'b0;
        errors = 0;
        result_count = 0;
        accepted = 0;
        sleeps_seen = 0;
        woken_total = 0;
        drain_mode = 1'b0;
        sched_reset();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue and empty sleep list after reset
        dir_tab.push_back(mk(rfds_pkg::MODE_DEQ, 4'd0, 32'd0, 1, 4'd0, 0, 5'd0));
        dir_tab.push_back(mk(rfds_pkg::MODE_TICK, 4'd0, 32'd0, 1, 4'd0, 0, 5'd0));
        dir_tab.push_back(mk(rfds_pkg::MODE_ENQ, 4'd15, 32'd0, 1, 4'd0, 0, 5'd0));
        dir_tab.push_back(mk(rfds_pkg::MODE_ENQ, 4'd0, 32'd0, 1, 4'd0, 0, 5'd0));
        dir_tab.push_back(mk(rfds_pkg::MODE_DEQ, 4'd0, 32'd0, 1, 4'd15, 1, 5'd0));
        dir_tab.push_back(mk(rfds_pkg::MODE_DEQ, 4'd0, 32'd0, 1, 4'd0, 1, 5'd0));
        dir_tab.push_back(mk(rfds_pkg::MODE_DEQ, 4'd9, 32'hFFFF_FFFF, 1, 4'd0, 0, 5'd0));
        // zero duration sleeps do nothing
        dir_tab.push_back(mk(rfds_pkg::MODE_SLEEP, 4'd3, 32'd0, 1, 4'd0, 0, 5'd0));
        dir_tab.push_back(mk(rfds_pkg::MODE_TICK, 4'd0, 32'd0, 1, 4'd0, 0, 5'd0));
        dir_tab.push_back(mk(rfds_pkg::MODE_SLEEP, 4'd1, 32'd1, 1, 4'd0, 0, 5'd0));
        dir_tab.push_back(mk(rfds_pkg::MODE_SLEEP, 4'd2, 32'd1, 0, 0, 0, 0));
        dir_tab.push_back(mk(rfds_pkg::MODE_SLEEP, 4'd4, 32'd3, 0, 0, 0, 0));
        dir_tab.push_back(mk(rfds_pkg::MODE_SLEEP, 4'd5, 32'd2, 0, 0, 0, 0));
        dir_tab.push_back(mk(rfds_pkg::MODE_TICK, 4'd0, 32'd0, 1, 4'd0, 0, 5'd2));
        dir_tab.push_back(mk(rfds_pkg::MODE_TICK, 4'd0, 32'd0, 0, 0, 0, 0));
        dir_tab.push_back(mk(rfds_pkg::MODE_TICK, 4'd0, 32'd0, 0, 0, 0, 0));
        dir_tab.push_back(mk(rfds_pkg::MODE_DEQ, 4'd0, 32'd0, 1, 4'd1, 1, 5'd0));
        // largest duration, then a duplicate sleep of the same thread
        dir_tab.push_back(mk(rfds_pkg::MODE_SLEEP, 4'd7, 32'hFFFF_FFFF, 0, 0, 0, 0));
        dir_tab.push_back(mk(rfds_pkg::MODE_SLEEP, 4'd8, 32'h8000_0000, 0, 0, 0, 0));
        dir_tab.push_back(mk(rfds_pkg::MODE_SLEEP, 4'd8, 32'h0000_0001, 0, 0, 0, 0));
        dir_tab.push_back(mk(rfds_pkg::MODE_TICK, 4'd0, 32'd0, 0, 0, 0, 0));
        dir_tab.push_back(mk(rfds_pkg::MODE_ENQ, 4'd10, 32'hAAAA_5555, 0, 0, 0, 0));
        dir_tab.push_back(mk(rfds_pkg::MODE_ENQ, 4'd10, 32'h5555_AAAA, 0, 0, 0, 0));
        dir_tab.push_back(mk(rfds_pkg::MODE_DEQ, 4'd0, 32'd0, 0, 0, 0, 0));
        foreach (dir_tab[i])
            send_request(dir_tab[i]);

        for (int n = 0; n < 500; n++)
        begin
            if (n >= 440)
                drain_mode = 1'b1;
            pick = $urandom_range(0, 99);
            row = mk(rfds_pkg::MODE_TICK, 4'($urandom_range(0, 15)), $urandom, 0, 0, 0, 0);
            if (pick < 25)
                row.mode = rfds_pkg::MODE_ENQ;
            else if (pick < 45)
                row.mode = rfds_pkg::MODE_DEQ;
            else if (pick < 70)
            begin
                row.mode = rfds_pkg::MODE_SLEEP;
                // mostly short sleeps so ticks wake things; some wide or zero
                case ($urandom_range(0, 9))
                    0: d = 32'd0;
                    1: d = $urandom;
                    2: d = 32'hFFFF_FFFF;
                    default: d = 32'($urandom_range(1, 6));
                endcase
                row.dur = d;
            end
            send_request(row);
        end
        s_tvalid <= 1'b0;

        guard = 0;
        while (expected_q.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (40) @(posedge clk);
        $display("covered %0d requests (%0d sleeps), %0d results, %0d threads woken",
                 accepted, sleeps_seen, result_count, woken_total);
        if (errors == 0 && expected_q.size() == 0)
            $display("tb_ready_fifo_and_delta_sleep_list: done, clean");
        else
            $display("tb_ready_fifo_and_delta_sleep_list: done, errors");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("tb_ready_fifo_and_delta_sleep_list: done, errors");
        $finish;
    end
endmodule
`default_nettype wire
